[rtl/core/sha256sh_pkg.sv]
// Shared types and constants for the streaming SHA-256 hasher.
// Used by sha256sh_ctrl, sha256sh_dp and sha256_stream_hasher_unit; no dependencies.
package sha256sh_pkg;

   // Field widths
   localparam int unsigned LenWidth   = 61;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned IdxWidth   = 3;
   localparam int unsigned CntWidth   = 6;
   localparam int unsigned RspDataWidth = 40;

   // Function codes carried on req_tuser
   localparam logic FUNC_ABSORB = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   // Result status codes carried on rsp_tuser
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // Source of the byte shifted into the block buffer
   localparam logic [1:0] SEL_DATA = 2'd0;
   localparam logic [1:0] SEL_MARK = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;
   localparam logic [1:0] SEL_LEN  = 2'd3;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [CntWidth-1:0] LEN_POS = 6'd56;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Commands from controller to datapath
   typedef struct packed {
      logic                shift_en;   // shift one byte into the block buffer
      logic [1:0]          shift_sel;  // byte source
      logic                count_en;   // count a message byte
      logic                round_en;   // run one compression round
      logic                chain_add;  // fold working vars into the chain
      logic                chain_init; // back to the initial vector
      logic                out_load;   // load the result register
      logic                out_ovf;    // result is an overflow report
      logic                out_last;   // result closes the item
      logic [CntWidth-1:0] idx;        // round, length byte or word index
   } sha256sh_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic fill_last;  // buffer holds 63 bytes
      logic fill_len;   // buffer holds 56 bytes
      logic overflow;   // byte count at or above the limit
      logic out_free;   // result register can take a word
   } sha256sh_stat_type;

endpackage

[rtl/core/sha256sh_ctrl.sv]
// Sequencer for the SHA-256 hasher: absorb, padding, rounds and digest output.
// Depends on sha256sh_pkg; drives sha256sh_dp through the command struct.
module sha256sh_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_func,
   input  sha256sh_pkg::sha256sh_stat_type stat,
   output sha256sh_pkg::sha256sh_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_OVF   = 3'd1;
   localparam logic [2:0] ST_MARK  = 3'd2;
   localparam logic [2:0] ST_ZERO  = 3'd3;
   localparam logic [2:0] ST_LEN   = 3'd4;
   localparam logic [2:0] ST_ROUND = 3'd5;
   localparam logic [2:0] ST_ADD   = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0]                        state_ff, state_in;
   logic [sha256sh_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic                              fin_ff, fin_in;      // finishing a message
   logic                              lendone_ff, lendone_in; // length bytes shifted

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      fin_in     = fin_ff;
      lendone_in = lendone_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.shift_sel = sha256sh_pkg::SEL_DATA;
      cmd.idx    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_func == sha256sh_pkg::FUNC_FINISH) begin
                  fin_in     = 1'b1;
                  lendone_in = 1'b0;
                  state_in   = ST_MARK;
               end else if (stat.overflow) begin
                  state_in = ST_OVF;
               end else begin
                  cmd.shift_en = 1'b1;
                  cmd.count_en = 1'b1;
                  if (stat.fill_last) begin
                     cnt_in   = '0;
                     state_in = ST_ROUND;
                  end
               end
            end
         end
         ST_OVF: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_ovf  = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MARK: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = sha256sh_pkg::SEL_MARK;
            cnt_in        = '0;
            state_in      = stat.fill_last ? ST_ROUND : ST_ZERO;
         end
         ST_ZERO: begin
            cnt_in = '0;
            if (stat.fill_len) begin
               state_in = ST_LEN;
            end else begin
               cmd.shift_en  = 1'b1;
               cmd.shift_sel = sha256sh_pkg::SEL_ZERO;
               if (stat.fill_last) begin
                  state_in = ST_ROUND;
               end
            end
         end
         ST_LEN: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_sel = sha256sh_pkg::SEL_LEN;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == 3'd7) begin
               lendone_in = 1'b1;
               cnt_in     = '0;
               state_in   = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.chain_add = 1'b1;
            cnt_in        = '0;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (lendone_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (cnt_ff[2:0] == 3'd7);
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff[2:0] == 3'd7) begin
                  cmd.chain_init = 1'b1;
                  fin_in         = 1'b0;
                  cnt_in         = '0;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         fin_ff     <= 1'b0;
         lendone_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         fin_ff     <= fin_in;
         lendone_ff <= lendone_in;
      end
   end

endmodule

[rtl/core/sha256sh_dp.sv]
// Datapath of the SHA-256 hasher: block buffer and message schedule window,
// round unit, chaining value, counters, length limit and result register.
// Depends on sha256sh_pkg; controlled by sha256sh_ctrl.
module sha256sh_dp (
   input  logic                                       clock,
   input  logic                                       reset,
   input  sha256sh_pkg::sha256sh_cmd_type             cmd,
   output sha256sh_pkg::sha256sh_stat_type            stat,
   input  logic [sha256sh_pkg::ByteWidth-1:0]         req_byte,
   input  logic                                       csr_we,
   input  logic [sha256sh_pkg::LenWidth-1:0]          csr_wdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [sha256sh_pkg::WordWidth-1:0]         rsp_word,
   output logic [sha256sh_pkg::IdxWidth-1:0]          rsp_index,
   output logic                                       rsp_last,
   output logic                                       rsp_status
);

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   logic [sha256sh_pkg::LenWidth-1:0] max_ff, max_in;
   logic [sha256sh_pkg::LenWidth-1:0] bcnt_ff, bcnt_in;
   logic [sha256sh_pkg::CntWidth-1:0] fill_ff, fill_in;
   logic [7:0][31:0]                  chain_ff, chain_in;
   logic [7:0][31:0]                  work_ff, work_in;   // a..h, a at index 0
   logic [511:0]                      block_ff, block_in; // earliest byte at the top
   logic                              out_valid_ff, out_valid_in;
   logic [31:0]                       out_word_ff, out_word_in;
   logic [2:0]                        out_idx_ff, out_idx_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_status_ff, out_status_in;

   logic [63:0] len_bits;
   logic [7:0]  shift_byte;
   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] s0, s1, big0, big1, ch, mj, t1, t2;

   // Status to the controller
   always_comb begin
      stat.fill_last = (fill_ff == '1);
      stat.fill_len  = (fill_ff == sha256sh_pkg::LEN_POS);
      stat.overflow  = (bcnt_ff >= max_ff);
      stat.out_free  = !out_valid_ff || rsp_tready;
   end

   // Byte source for the buffer
   assign len_bits = {bcnt_ff, 3'b000};
   always_comb begin
      unique case (cmd.shift_sel)
         sha256sh_pkg::SEL_DATA: shift_byte = req_byte;
         sha256sh_pkg::SEL_MARK: shift_byte = sha256sh_pkg::PAD_MARK;
         sha256sh_pkg::SEL_ZERO: shift_byte = '0;
         sha256sh_pkg::SEL_LEN:  shift_byte = len_bits[{~cmd.idx[2:0], 3'b000} +: 8];
         default:                shift_byte = '0;
      endcase
   end

   // Message schedule window
   assign w0    = block_ff[511:480];
   assign w1    = block_ff[479:448];
   assign w9    = block_ff[223:192];
   assign w14   = block_ff[63:32];
   assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
   assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
   assign w_new = w0 + s0 + w9 + s1;

   // Round function
   assign big0 = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
   assign big1 = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
   assign ch   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign mj   = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
               ^ (work_ff[1] & work_ff[2]);
   assign t1   = work_ff[7] + big1 + ch + sha256sh_pkg::ROUND_K[cmd.idx] + w0;
   assign t2   = big0 + mj;

   // Buffer, working variables and chain
   always_comb begin
      block_in = block_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      fill_in  = fill_ff;
      bcnt_in  = bcnt_ff;
      max_in   = csr_we ? csr_wdata : max_ff;
      if (cmd.shift_en) begin
         block_in = {block_ff[503:0], shift_byte};
         fill_in  = fill_ff + 1'b1;
         work_in  = chain_ff;
      end
      if (cmd.count_en) begin
         bcnt_in = bcnt_ff + 1'b1;
      end
      if (cmd.round_en) begin
         block_in   = {block_ff[479:0], w_new};
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
      if (cmd.chain_add) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.chain_init) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = sha256sh_pkg::INIT_HASH[i];
         end
         fill_in = '0;
         bcnt_in = '0;
      end
   end

   // Result register
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_word_in   = out_word_ff;
      out_idx_in    = out_idx_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_last_in  = cmd.out_last;
         if (cmd.out_ovf) begin
            out_word_in   = '0;
            out_idx_in    = '0;
            out_status_in = sha256sh_pkg::STATUS_OVERFLOW;
         end else begin
            out_word_in   = chain_ff[cmd.idx[2:0]];
            out_idx_in    = cmd.idx[2:0];
            out_status_in = sha256sh_pkg::STATUS_OK;
         end
      end
   end

   // State with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= '1;
         bcnt_ff      <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha256sh_pkg::INIT_HASH[i];
         end
      end else begin
         max_ff       <= max_in;
         bcnt_ff      <= bcnt_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      block_ff      <= block_in;
      work_ff       <= work_in;
      out_word_ff   <= out_word_in;
      out_idx_ff    <= out_idx_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_word   = out_word_ff;
   assign rsp_index  = out_idx_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_status = out_status_ff;

endmodule

[rtl/core/sha256_stream_hasher_unit.sv]
// Streaming SHA-256 hasher. An absorb word shifts one byte into the block buffer; every 64th
// byte starts 64 rounds on the single round unit plus the chain add.
// A finish word pads and compresses one block, or, if the length bytes do not fit, compresses
// a second padded block as well; the eight digest words follow. Overflow gives one status word.
// Synchronous active-high reset restores the initial vector, clears the counts
// and sets the length limit to 2^61-1; there is no clearing pass.
module sha256_stream_hasher_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,  // data_byte
   input  logic                                      req_tuser,  // func
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [sha256sh_pkg::RspDataWidth-1:0]     rsp_tdata,  // digest_word, word_index, zeros
   output logic                                      rsp_tlast,  // last_word
   output logic                                      rsp_tuser,  // status
   input  logic                                      csr_we,
   input  logic [sha256sh_pkg::LenWidth-1:0]         csr_wdata   // max_message_bytes
);

   sha256sh_pkg::sha256sh_cmd_type  cmd;
   sha256sh_pkg::sha256sh_stat_type stat;
   logic [sha256sh_pkg::WordWidth-1:0] rsp_word;
   logic [sha256sh_pkg::IdxWidth-1:0]  rsp_index;

   sha256sh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   sha256sh_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_byte   (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word),
      .rsp_index  (rsp_index),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_tuser)
   );

   assign rsp_tdata = {5'b00000, rsp_index, rsp_word};

endmodule
